// ===== src/nbcr_pkg.sv =====
// ----------------------------------------------------------------------------
// nbcr_pkg: shared types and constants of the network boot command receiver
// Holds the transaction payload structs, event and command codes,
// acknowledgement codes, register indexes and reset values.
// ----------------------------------------------------------------------------
`default_nettype none

package nbcr_pkg;

    localparam int MaxFrameBytesDefault = 2048;

    localparam int HdrBytes = 16;

    localparam logic [1:0] KIND_PACKET = 2'd0;
    localparam logic [1:0] KIND_LINK_UP = 2'd1;
    localparam logic [1:0] KIND_LINK_DOWN = 2'd2;
    localparam logic [1:0] KIND_TIMER = 2'd3;

    localparam logic [2:0] CMD_EXECUTE = 3'd0;
    localparam logic [2:0] CMD_SEND_FILE = 3'd1;
    localparam logic [2:0] CMD_DATA = 3'd2;
    localparam logic [2:0] CMD_LAST_DATA = 3'd3;
    localparam logic [2:0] CMD_BOOT = 3'd4;
    localparam logic [2:0] CMD_QUERY = 3'd5;

    localparam logic [2:0] ACK_OK = 3'd0;
    localparam logic [2:0] ACK_FILE_RECEIVED = 3'd1;
    localparam logic [2:0] ACK_BAD_FILE = 3'd2;
    localparam logic [2:0] ACK_TOO_LARGE = 3'd3;
    localparam logic [2:0] ACK_BAD_COMMAND = 3'd4;

    localparam logic [1:0] REG_FAST_TICK_COUNT = 2'd0;
    localparam logic [1:0] REG_FAST_PERIOD_MS = 2'd1;
    localparam logic [1:0] REG_SLOW_PERIOD_MS = 2'd2;

    localparam logic [4:0] FAST_TICK_COUNT_RESET = 5'd20;
    localparam logic [15:0] FAST_PERIOD_MS_RESET = 16'd100;
    localparam logic [15:0] SLOW_PERIOD_MS_RESET = 16'd1000;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] cookie;
        logic [2:0]  command;
        logic [31:0] argument;
        logic [11:0] frame_bytes;
        logic        file_granted;
        logic [31:0] granted_size;
    } t_in;

    typedef struct packed {
        logic        send_ack;
        logic [31:0] ack_cookie;
        logic [2:0]  ack_code;
        logic [31:0] ack_argument;
        logic        send_query_reply;
        logic        send_advertise;
        logic        write_enable;
        logic [31:0] write_offset;
        logic [11:0] write_length;
        logic        boot_request;
        logic [15:0] timer_reload_ms;
    } t_out;

endpackage

`default_nettype wire

// ===== src/netboot_command_receiver.sv =====
// ----------------------------------------------------------------------------
// netboot_command_receiver: device side of the network boot command protocol
// Turns decoded packet headers and link and timer events into acknowledgement,
// write, boot, query and announcement requests.
// ----------------------------------------------------------------------------
// One input transaction is taken per clock cycle. Its result appears in the
// output register on the next cycle and stays there until the output side
// takes it; the input side is stalled only while that register is full and
// the output is stalled. All protocol state (command history, file position,
// timer phase) is updated in the same cycle the transaction is accepted, so
// the throughput is one transaction per cycle while the output is not stalled.
// The configuration port is always ready and should be written while idle.
`default_nettype none

module netboot_command_receiver #(
    parameter int MAX_FRAME_BYTES = nbcr_pkg::MaxFrameBytesDefault
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    output      logic           o_in_stall,
    input  wire nbcr_pkg::t_in  i_in_data,
    output      logic           o_out_valid,
    input  wire logic           i_out_stall,
    output      nbcr_pkg::t_out o_out_data,
    input  wire logic           i_cfg_valid,
    output      logic           o_cfg_ready,
    input  wire logic [1:0]     i_cfg_index,
    input  wire logic [15:0]    i_cfg_data
);
    import nbcr_pkg::*;

    localparam logic [16:0] MaxFrame = 17'(MAX_FRAME_BYTES);

    logic [4:0]  r_fast_tick_count;
    logic [15:0] r_fast_period_ms;
    logic [15:0] r_slow_period_ms;

    logic        r_history_valid, n_history_valid;
    logic [31:0] r_prev_cookie, n_prev_cookie;
    logic [2:0]  r_prev_command, n_prev_command;
    logic [31:0] r_prev_argument, n_prev_argument;
    logic [2:0]  r_prev_ack_code, n_prev_ack_code;
    logic [31:0] r_prev_ack_argument, n_prev_ack_argument;
    logic        r_file_open, n_file_open;
    logic [31:0] r_file_position, n_file_position;
    logic [31:0] r_file_capacity, n_file_capacity;
    logic        r_transfer_active, n_transfer_active;
    logic        r_link_online, n_link_online;
    logic [4:0]  r_fast_remaining, n_fast_remaining;

    logic        r_out_valid;
    t_out        r_out, n_out;

    logic        accept;
    logic [11:0] len;
    logic        frame_ok;
    logic        repeat_hit;
    logic        overflow;
    logic        store;
    logic        transmit;
    logic [2:0]  code;
    logic [31:0] aarg;

    assign o_in_stall = r_out_valid && i_out_stall;
    assign accept = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_data = r_out;
    assign o_cfg_ready = 1'b1;

    assign len = i_in_data.frame_bytes - 12'(HdrBytes);
    assign frame_ok = ({5'd0, i_in_data.frame_bytes} >= 17'(HdrBytes))
                      && ({5'd0, i_in_data.frame_bytes} <= MaxFrame);
    assign repeat_hit = r_history_valid && (i_in_data.cookie == r_prev_cookie)
                        && (i_in_data.command == r_prev_command)
                        && (i_in_data.argument == r_prev_argument);
    assign overflow = ({1'b0, r_file_position} + {21'd0, len})
                      > {1'b0, r_file_capacity};

    always_comb begin
        n_history_valid = r_history_valid;
        n_prev_cookie = r_prev_cookie;
        n_prev_command = r_prev_command;
        n_prev_argument = r_prev_argument;
        n_prev_ack_code = r_prev_ack_code;
        n_prev_ack_argument = r_prev_ack_argument;
        n_file_open = r_file_open;
        n_file_position = r_file_position;
        n_file_capacity = r_file_capacity;
        n_transfer_active = r_transfer_active;
        n_link_online = r_link_online;
        n_fast_remaining = r_fast_remaining;
        n_out = '0;
        store = 1'b0;
        transmit = 1'b1;
        code = ACK_OK;
        aarg = '0;
        case (i_in_data.kind)
            KIND_LINK_UP: begin
                if (!r_link_online) begin
                    n_link_online = 1'b1;
                    n_fast_remaining = r_fast_tick_count;
                    n_out.timer_reload_ms = r_fast_period_ms;
                    n_out.send_advertise = 1'b1;
                end
            end
            KIND_LINK_DOWN: begin
                n_link_online = 1'b0;
            end
            KIND_TIMER: begin
                if (r_link_online) begin
                    if (r_fast_remaining != 5'd0) begin
                        n_fast_remaining = r_fast_remaining - 5'd1;
                        n_out.timer_reload_ms = r_fast_period_ms;
                    end else begin
                        n_out.timer_reload_ms = r_slow_period_ms;
                    end
                    if (r_transfer_active) begin
                        n_transfer_active = 1'b0;
                    end else begin
                        n_out.send_advertise = 1'b1;
                    end
                end
            end
            default: begin
                if (frame_ok && repeat_hit) begin
                    n_transfer_active = 1'b1;
                    n_out.send_ack = 1'b1;
                    n_out.ack_cookie = r_prev_cookie;
                    n_out.ack_code = r_prev_ack_code;
                    n_out.ack_argument = r_prev_ack_argument;
                end else if (frame_ok) begin
                    case (i_in_data.command)
                        CMD_EXECUTE: begin
                            store = (len != 12'd0);
                        end
                        CMD_SEND_FILE: begin
                            store = (len != 12'd0);
                            if (store && i_in_data.file_granted) begin
                                n_file_open = 1'b1;
                                n_file_position = '0;
                                n_file_capacity = i_in_data.granted_size;
                                aarg = i_in_data.argument;
                            end else if (store) begin
                                n_file_open = 1'b0;
                                code = ACK_BAD_FILE;
                            end
                        end
                        CMD_DATA, CMD_LAST_DATA: begin
                            store = r_file_open;
                            if (i_in_data.argument != r_file_position) begin
                                aarg = r_file_position;
                            end else if (overflow) begin
                                code = ACK_TOO_LARGE;
                                aarg = i_in_data.argument;
                            end else if (r_file_open) begin
                                n_out.write_enable = 1'b1;
                                n_out.write_offset = r_file_position;
                                n_out.write_length = len;
                                n_file_position = r_file_position + {20'd0, len};
                                if (i_in_data.command == CMD_LAST_DATA) begin
                                    code = ACK_FILE_RECEIVED;
                                end else begin
                                    transmit = 1'b0;
                                end
                            end
                        end
                        CMD_BOOT: begin
                            store = 1'b1;
                            n_out.boot_request = 1'b1;
                        end
                        CMD_QUERY: begin
                            n_out.send_query_reply = 1'b1;
                            n_out.ack_cookie = i_in_data.cookie;
                        end
                        default: begin
                            store = 1'b1;
                            code = ACK_BAD_COMMAND;
                        end
                    endcase
                    if (store) begin
                        n_history_valid = 1'b1;
                        n_prev_cookie = i_in_data.cookie;
                        n_prev_command = i_in_data.command;
                        n_prev_argument = i_in_data.argument;
                        n_prev_ack_code = code;
                        n_prev_ack_argument = aarg;
                        n_transfer_active = 1'b1;
                        n_out.send_ack = transmit;
                        n_out.ack_cookie = i_in_data.cookie;
                        n_out.ack_code = code;
                        n_out.ack_argument = aarg;
                    end
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fast_tick_count <= FAST_TICK_COUNT_RESET;
            r_fast_period_ms <= FAST_PERIOD_MS_RESET;
            r_slow_period_ms <= SLOW_PERIOD_MS_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_FAST_TICK_COUNT: r_fast_tick_count <= i_cfg_data[4:0];
                REG_FAST_PERIOD_MS: r_fast_period_ms <= i_cfg_data;
                REG_SLOW_PERIOD_MS: r_slow_period_ms <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_history_valid <= 1'b0;
            r_prev_cookie <= '0;
            r_prev_command <= '0;
            r_prev_argument <= '0;
            r_prev_ack_code <= '0;
            r_prev_ack_argument <= '0;
            r_file_open <= 1'b0;
            r_file_position <= '0;
            r_file_capacity <= '0;
            r_transfer_active <= 1'b0;
            r_link_online <= 1'b0;
            r_fast_remaining <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_history_valid <= n_history_valid;
                r_prev_cookie <= n_prev_cookie;
                r_prev_command <= n_prev_command;
                r_prev_argument <= n_prev_argument;
                r_prev_ack_code <= n_prev_ack_code;
                r_prev_ack_argument <= n_prev_ack_argument;
                r_file_open <= n_file_open;
                r_file_position <= n_file_position;
                r_file_capacity <= n_file_capacity;
                r_transfer_active <= n_transfer_active;
                r_link_online <= n_link_online;
                r_fast_remaining <= n_fast_remaining;
            end
            if (accept) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out <= n_out;
        end
    end

`ifndef SYNTHESIS
    a_position_in_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_file_open |-> (r_file_position <= r_file_capacity))
        else $error("File position beyond buffer capacity.");

    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |=> (r_out_valid && $stable(r_out)))
        else $error("Stalled result changed or was lost.");

    a_advertise_online: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.send_advertise) |-> r_link_online)
        else $error("Announcement requested while the link is down.");

    a_write_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.write_enable)
        |-> (!r_out.send_query_reply && !r_out.boot_request && !r_out.send_advertise))
        else $error("Write request combined with another request.");
`endif

endmodule

`default_nettype wire
